[rtl/core/fplr_pkg.sv]
package fplr_pkg;

  localparam int NUM_CODES   = 256;
  localparam int MAX_WIDTH   = 16;
  localparam int MAX_HEIGHT  = 16;
  localparam int LINE_PIXELS = 1024;

  localparam int CODE_W  = 8;
  localparam int ROW_W   = 4;
  localparam int BITS_W  = 16;
  localparam int ADV_W   = 5;
  localparam int COLOR_W = 8;
  localparam int X_W     = 10;
  localparam int PEN_W   = 11;
  localparam int CFG_W   = 9;
  localparam int IDX_W   = 2;

  localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CHAR_COUNT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_WIDTH    = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPACE_WIDTH  = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_APPEND,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    KIND_GLYPH,
    KIND_SPACE,
    KIND_BLANK
  } kind_t;

  typedef struct packed {
    op_t                op;
    kind_t              kind;
    logic [CODE_W-1:0]  code;
    logic [ROW_W-1:0]   row;
    logic [BITS_W-1:0]  bits;
    logic [ADV_W-1:0]   width;
    logic [COLOR_W-1:0] color;
    logic [X_W-1:0]     px;
    logic [ROW_W-1:0]   py;
    logic               py_ok;
  } cmd_t;

  typedef struct packed {
    logic [ADV_W-1:0] height_eff;
    logic [ADV_W-1:0] max_width;
    logic [ADV_W-1:0] space_width;
  } cfg_t;

endpackage

[rtl/core/fplr_front.sv]
module fplr_front import fplr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               queue_full,
  input  logic [1:0]         operation,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [ROW_W-1:0]   glyph_row,
  input  logic [BITS_W-1:0]  row_bits,
  input  logic [ADV_W-1:0]   char_width,
  input  logic [COLOR_W-1:0] fg_color,
  input  logic [X_W-1:0]     pixel_x,
  input  logic [ROW_W-1:0]   pixel_y,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               busy,
  output logic               push,
  output cmd_t               cmd,
  output cfg_t               cfg
);

  logic [CFG_W-1:0] char_count;
  logic [ADV_W-1:0] glyph_height;
  logic [ADV_W-1:0] max_glyph_width;
  logic [ADV_W-1:0] space_width;
  logic [ADV_W-1:0] height_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= 9'd256;
      glyph_height    <= 5'd8;
      max_glyph_width <= 5'd8;
      space_width     <= 5'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHAR_COUNT:   char_count      <= cfg_data;
        REG_GLYPH_HEIGHT: glyph_height    <= cfg_data[ADV_W-1:0];
        REG_MAX_WIDTH:    max_glyph_width <= cfg_data[ADV_W-1:0];
        REG_SPACE_WIDTH:  space_width     <= cfg_data[ADV_W-1:0];
        default: ;
      endcase
    end
  end

  assign height_eff = (glyph_height > ADV_W'(MAX_HEIGHT)) ? ADV_W'(MAX_HEIGHT) : glyph_height;

  assign cfg.height_eff  = height_eff;
  assign cfg.max_width   = max_glyph_width;
  assign cfg.space_width = space_width;

  assign busy = queue_full;
  assign push = start && !queue_full;

  // classify the item before it enters the queue
  always_comb begin
    cmd.op    = op_t'(operation);
    cmd.code  = char_code;
    cmd.row   = glyph_row;
    cmd.bits  = row_bits;
    cmd.width = (char_width > ADV_W'(MAX_WIDTH)) ? ADV_W'(MAX_WIDTH) : char_width;
    cmd.color = fg_color;
    cmd.px    = pixel_x;
    cmd.py    = pixel_y;
    cmd.py_ok = {1'b0, pixel_y} < height_eff;
    if ({1'b0, char_code} >= char_count) begin
      cmd.kind = KIND_BLANK;
    end else if (char_code == SPACE_CODE) begin
      cmd.kind = KIND_SPACE;
    end else begin
      cmd.kind = KIND_GLYPH;
    end
  end

endmodule

[rtl/core/fplr_queue.sv]
module fplr_queue import fplr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic not_empty,
  output logic full
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr          <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

endmodule

[rtl/core/fplr_back.sv]
module fplr_back import fplr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               head,
  input  logic               not_empty,
  input  cfg_t               cfg,
  output logic               pop,
  output logic               done,
  output logic [PEN_W-1:0]   line_width,
  output logic [COLOR_W-1:0] pixel_value,
  output logic               overflow
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DRAW
  } state_t;

  state_t             state;
  cmd_t               cmd;
  logic [PEN_W-1:0]   pen;
  logic [COLOR_W-1:0] color;
  logic               ovf;
  logic [ADV_W-1:0]   adv;
  logic [ADV_W-1:0]   cnt;

  // glyph store: one bank per glyph row so all rows of a glyph read together
  logic [BITS_W-1:0]  rows_q [MAX_HEIGHT];
  logic [ADV_W-1:0]   width_mem [NUM_CODES];
  logic [ADV_W-1:0]   width_q;
  logic [MAX_HEIGHT-1:0] line_mem [LINE_PIXELS];
  logic [MAX_HEIGHT-1:0] column_q;

  logic                  load_we;
  logic                  line_we;
  logic [X_W-1:0]        line_addr;
  logic [MAX_HEIGHT-1:0] line_data;
  logic [MAX_HEIGHT-1:0] glyph_col;
  logic [PEN_W:0]        pos;
  logic [PEN_W:0]        pen_sum;

  assign pop     = (state == S_IDLE) && not_empty;
  assign load_we = pop && (head.op == OP_LOAD);

  for (genvar g = 0; g < MAX_HEIGHT; g++) begin : g_bank
    logic [BITS_W-1:0] bank [NUM_CODES];
    always_ff @(posedge clk) begin
      if (load_we && (head.row == ROW_W'(g))) begin
        bank[head.code] <= head.bits;
      end
      // rows stay put while the glyph is drawn
      if (pop) begin
        rows_q[g] <= bank[head.code];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      width_mem[head.code] <= head.width;
    end
    width_q <= width_mem[head.code];
  end

  // column cnt of the glyph, rows above the line height blanked
  always_comb begin
    for (int y = 0; y < MAX_HEIGHT; y++) begin
      glyph_col[y] = rows_q[y][cnt[3:0]] && (ADV_W'(y) < cfg.height_eff);
    end
  end

  assign pos       = {1'b0, pen} + {{(PEN_W+1-ADV_W){1'b0}}, cnt};
  assign pen_sum   = {1'b0, pen} + {{(PEN_W+1-ADV_W){1'b0}}, adv};
  assign line_we   = (state == S_DRAW) && (cnt < adv) && (pos < (PEN_W+1)'(LINE_PIXELS));
  assign line_addr = pos[X_W-1:0];
  assign line_data = (cmd.kind == KIND_GLYPH) ? glyph_col : '0;

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_addr] <= line_data;
    end
    column_q <= line_mem[head.px];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pen         <= '0;
      color       <= '0;
      ovf         <= 1'b0;
      done        <= 1'b0;
      line_width  <= '0;
      pixel_value <= '0;
      overflow    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (not_empty) begin
            cmd <= head;
            case (head.op)
              OP_LOAD: begin
                done        <= 1'b1;
                line_width  <= pen;
                pixel_value <= '0;
                overflow    <= ovf;
              end
              OP_START: begin
                pen         <= '0;
                color       <= head.color;
                ovf         <= 1'b0;
                done        <= 1'b1;
                line_width  <= '0;
                pixel_value <= '0;
                overflow    <= 1'b0;
              end
              default: state <= S_FETCH;
            endcase
          end
        end
        S_FETCH: begin
          if (cmd.op == OP_READ) begin
            done        <= 1'b1;
            line_width  <= pen;
            overflow    <= ovf;
            pixel_value <= ({1'b0, cmd.px} < pen && cmd.py_ok && column_q[cmd.py]) ?
                           color : '0;
            state       <= S_IDLE;
          end else begin
            case (cmd.kind)
              KIND_GLYPH: adv <= width_q;
              KIND_SPACE: adv <= cfg.space_width;
              default:    adv <= cfg.max_width;
            endcase
            cnt   <= '0;
            state <= S_DRAW;
          end
        end
        S_DRAW: begin
          if (cnt < adv) begin
            cnt <= cnt + ADV_W'(1);
          end else begin
            done        <= 1'b1;
            pixel_value <= '0;
            state       <= S_IDLE;
            if (pen_sum > (PEN_W+1)'(LINE_PIXELS)) begin
              pen        <= PEN_W'(LINE_PIXELS);
              ovf        <= 1'b1;
              line_width <= PEN_W'(LINE_PIXELS);
              overflow   <= 1'b1;
            end else begin
              pen        <= pen_sum[PEN_W-1:0];
              line_width <= pen_sum[PEN_W-1:0];
              overflow   <= ovf;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/proportional_font_line_renderer_core.sv]
// Proportional font line renderer. Pulse start while busy is low to hand in
// one command (load glyph row, start string, append character, read pixel);
// every command gives exactly one result, shown for a single cycle while done
// is high, and the receiver cannot stall it. Commands pass a two-entry queue,
// so up to two can be taken while earlier ones are still running. A load or a
// string start is answered straight from the queue head, a read after a fetch
// state, and an append after a fetch state and a draw state in which the line
// buffer takes one glyph column per cycle across its advance width. The line
// buffer, glyph store and width table hold garbage after reset until written;
// no clearing pass is run. Configuration may be written only while idle.
module proportional_font_line_renderer_core import fplr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [ROW_W-1:0]   glyph_row,
  input  logic [BITS_W-1:0]  row_bits,
  input  logic [ADV_W-1:0]   char_width,
  input  logic [COLOR_W-1:0] fg_color,
  input  logic [X_W-1:0]     pixel_x,
  input  logic [ROW_W-1:0]   pixel_y,
  // configuration write port
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  // result channel
  output logic               done,
  output logic [PEN_W-1:0]   line_width,
  output logic [COLOR_W-1:0] pixel_value,
  output logic               overflow
);

  cmd_t push_cmd;
  cmd_t head;
  cfg_t cfg;
  logic push;
  logic pop;
  logic not_empty;
  logic queue_full;

  // front: config registers and command classification
  fplr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .queue_full (queue_full),
    .operation  (operation),
    .char_code  (char_code),
    .glyph_row  (glyph_row),
    .row_bits   (row_bits),
    .char_width (char_width),
    .fg_color   (fg_color),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (busy),
    .push       (push),
    .cmd        (push_cmd),
    .cfg        (cfg)
  );

  // decouples the front from the column writer
  fplr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (queue_full)
  );

  // back: glyph store, line buffer, pen and result registers
  fplr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .not_empty   (not_empty),
    .cfg         (cfg),
    .pop         (pop),
    .done        (done),
    .line_width  (line_width),
    .pixel_value (pixel_value),
    .overflow    (overflow)
  );

endmodule

[sim/proportional_font_line_renderer_core_tb.sv]
module proportional_font_line_renderer_core_tb import fplr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // one command as handed to the renderer, every field at its port width
  typedef struct packed {
    op_t                op;
    logic [CODE_W-1:0]  code;
    logic [ROW_W-1:0]   row;
    logic [BITS_W-1:0]  bits;
    logic [ADV_W-1:0]   cw;
    logic [COLOR_W-1:0] color;
    logic [X_W-1:0]     px;
    logic [ROW_W-1:0]   py;
  } font_cmd_t;

  // what one command should report back
  typedef struct packed {
    logic [PEN_W-1:0]   width;
    logic [COLOR_W-1:0] pix;
    logic               ovf;
  } line_result_t;

  typedef struct {
    op_t          op;
    line_result_t res;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         operation;
  logic [CODE_W-1:0]  char_code;
  logic [ROW_W-1:0]   glyph_row;
  logic [BITS_W-1:0]  row_bits;
  logic [ADV_W-1:0]   char_width;
  logic [COLOR_W-1:0] fg_color;
  logic [X_W-1:0]     pixel_x;
  logic [ROW_W-1:0]   pixel_y;
  logic               cfg_write;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               done;
  logic [PEN_W-1:0]   line_width;
  logic [COLOR_W-1:0] pixel_value;
  logic               overflow;

  proportional_font_line_renderer_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .char_code   (char_code),
    .glyph_row   (glyph_row),
    .row_bits    (row_bits),
    .char_width  (char_width),
    .fg_color    (fg_color),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .line_width  (line_width),
    .pixel_value (pixel_value),
    .overflow    (overflow)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // renderer state as the testbench sees it
  // ---------------------------------------------------------------------------

  // register copies, updated on every write
  int font_count;
  int font_height;
  int font_maxw;
  int font_spacew;

  logic [BITS_W-1:0]  glyph_rows [NUM_CODES*MAX_HEIGHT];
  logic [ADV_W-1:0]   glyph_adv  [NUM_CODES];
  logic [MAX_HEIGHT-1:0] row_seen [NUM_CODES];   // which rows of a code were ever loaded
  logic [MAX_HEIGHT-1:0] line_cols [LINE_PIXELS];
  int                 pen;
  logic [COLOR_W-1:0] line_color;
  logic               line_ovf;

  // codes with all rows loaded, safe to draw as glyphs
  int   font_codes[$];
  bit   listed [NUM_CODES];

  pending_t pending_results[$];

  int gap_pct;        // chance in percent that the sender idles a given cycle
  int errors;
  int n_sent;
  int n_checked;
  int n_glyphs;
  int n_strings;
  int n_ovf_results;
  int n_solid_reads;

  // works out the result of one accepted command and moves the state on
  task automatic render_predict(input font_cmd_t c, output line_result_t r);
    int h, adv, pos, k, y, base;
    bit solid;
    logic [MAX_HEIGHT-1:0] col;
    logic [COLOR_W-1:0] pix;
    h = (font_height > MAX_HEIGHT) ? MAX_HEIGHT : font_height;
    base = int'(c.code) * MAX_HEIGHT;
    pix = '0;
    case (c.op)
      OP_LOAD: begin
        // rows and codes always fit, so every load lands
        glyph_rows[base + int'(c.row)] = c.bits;
        glyph_adv[c.code] = (c.cw > MAX_WIDTH) ? ADV_W'(MAX_WIDTH) : c.cw;
        row_seen[c.code][c.row] = 1'b1;
      end
      OP_START: begin
        line_color = c.color;
        pen = 0;
        line_ovf = 1'b0;
      end
      OP_APPEND: begin
        solid = 1'b0;
        if (int'(c.code) >= font_count) begin
          adv = font_maxw;             // outside the font: blank of the maximum width
        end else if (c.code == SPACE_CODE) begin
          adv = font_spacew;
        end else begin
          adv = int'(glyph_adv[c.code]);
          solid = 1'b1;
        end
        for (k = 0; k < adv; k++) begin
          pos = pen + k;
          col = '0;
          if (solid && k < MAX_WIDTH) begin
            for (y = 0; y < h; y++) col[y] = glyph_rows[base + y][k];
          end
          // columns past the line end are dropped
          if (pos < LINE_PIXELS) line_cols[pos] = col;
        end
        if (pen + adv > LINE_PIXELS) begin
          pen = LINE_PIXELS;
          line_ovf = 1'b1;
        end else begin
          pen = pen + adv;
        end
      end
      default: begin
        // read: only inside the drawn part and the glyph height
        if (int'(c.px) < pen && int'(c.py) < h && line_cols[c.px][c.py]) pix = line_color;
      end
    endcase
    r.width = PEN_W'(pen);
    r.pix = pix;
    r.ovf = line_ovf;
  endtask

  // a code may be appended unless it would draw rows that were never loaded
  function automatic bit char_ok(int code);
    return code >= font_count || code == int'(SPACE_CODE) || row_seen[code] == '1;
  endfunction

  // mostly loaded glyphs, with spaces, codes past the font and random codes
  function automatic int pick_char();
    int code, r;
    do begin
      r = $urandom_range(0, 9);
      if (r < 6 && font_codes.size() > 0)
        code = font_codes[$urandom_range(0, font_codes.size() - 1)];
      else if (r == 6)
        code = SPACE_CODE;
      else if (r == 7 && font_count < NUM_CODES)
        code = $urandom_range(font_count, NUM_CODES - 1);
      else
        code = $urandom_range(0, NUM_CODES - 1);
    end while (!char_ok(code));
    return code;
  endfunction

  // every field random; the callers then set what the operation uses
  function automatic font_cmd_t random_cmd();
    font_cmd_t c;
    c.op    = op_t'($urandom_range(0, 3));
    c.code  = CODE_W'($urandom);
    c.row   = ROW_W'($urandom);
    c.bits  = BITS_W'($urandom);
    c.cw    = ADV_W'($urandom);
    c.color = COLOR_W'($urandom);
    c.px    = X_W'($urandom);
    c.py    = ROW_W'($urandom);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // drive one command and hold it until the renderer takes the transfer
  task automatic send_item(input font_cmd_t c);
    int gap;
    pending_t p;
    gap = 0;
    while ($urandom_range(0, 99) < gap_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation  = c.op;
    char_code  = c.code;
    glyph_row  = c.row;
    row_bits   = c.bits;
    char_width = c.cw;
    fg_color   = c.color;
    pixel_x    = c.px;
    pixel_y    = c.py;
    start      = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // transfer taken at this edge
    render_predict(c, p.res);
    p.op = c.op;
    pending_results.push_back(p);
    n_sent++;
    if (c.op == OP_READ && p.res.pix != '0) n_solid_reads++;
  endtask

  task automatic load_row(int code, int row, int bits, int cw);
    font_cmd_t c;
    c = random_cmd();
    c.op   = OP_LOAD;
    c.code = CODE_W'(code);
    c.row  = ROW_W'(row);
    c.bits = BITS_W'(bits);
    c.cw   = ADV_W'(cw);
    send_item(c);
  endtask

  task automatic start_line(int color);
    font_cmd_t c;
    c = random_cmd();
    c.op    = OP_START;
    c.color = COLOR_W'(color);
    send_item(c);
    n_strings++;
  endtask

  task automatic append_char(int code);
    font_cmd_t c;
    c = random_cmd();
    c.op   = OP_APPEND;
    c.code = CODE_W'(code);
    send_item(c);
  endtask

  task automatic read_pixel(int x, int y);
    font_cmd_t c;
    c = random_cmd();
    c.op = OP_READ;
    c.px = X_W'(x);
    c.py = ROW_W'(y);
    send_item(c);
  endtask

  // reads aimed mostly at the drawn part of the line
  task automatic read_random();
    int x, y, h;
    h = (font_height > MAX_HEIGHT) ? MAX_HEIGHT : font_height;
    if (pen > 0 && $urandom_range(0, 9) < 7) x = $urandom_range(0, pen - 1);
    else x = $urandom_range(0, LINE_PIXELS - 1);
    if (h > 0 && $urandom_range(0, 9) < 8) y = $urandom_range(0, h - 1);
    else y = $urandom_range(0, MAX_HEIGHT - 1);
    read_pixel(x, y);
  endtask

  // all sixteen rows of one code, width taken from the last row
  task automatic define_glyph(int code, int width);
    int y, bits;
    for (y = 0; y < MAX_HEIGHT; y++) begin
      case ($urandom_range(0, 7))
        0:       bits = 0;
        1:       bits = 16'hFFFF;
        default: bits = $urandom;
      endcase
      load_row(code, y, bits, (y == MAX_HEIGHT - 1) ? width : $urandom_range(0, 31));
    end
    if (!listed[code]) begin
      listed[code] = 1'b1;
      font_codes.push_back(code);
    end
    n_glyphs++;
  endtask

  function automatic int glyph_width_choice();
    case ($urandom_range(0, 7))
      0, 1:    return MAX_WIDTH;
      2:       return $urandom_range(MAX_WIDTH + 1, 31);   // stored as the maximum
      default: return $urandom_range(0, MAX_WIDTH);
    endcase
  endfunction

  task automatic run_line(int n_chars);
    int i;
    start_line(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 255));
    for (i = 0; i < n_chars; i++) begin
      append_char(pick_char());
      if ($urandom_range(0, 2) == 0) read_random();
    end
    repeat ($urandom_range(2, 5)) read_random();
  endtask

  // lower start and wait until every result is back
  task automatic wait_results_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(value);
    case (idx)
      REG_CHAR_COUNT:   font_count  = value & 9'h1FF;
      REG_GLYPH_HEIGHT: font_height = value & 5'h1F;
      REG_MAX_WIDTH:    font_maxw   = value & 5'h1F;
      REG_SPACE_WIDTH:  font_spacew = value & 5'h1F;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // registers only change with the renderer idle
  task automatic set_font_regs(int cnt, int h, int mw, int sw);
    wait_results_drained();
    write_reg(REG_CHAR_COUNT, cnt);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_MAX_WIDTH, mw);
    write_reg(REG_SPACE_WIDTH, sw);
  endtask

  // ---------------------------------------------------------------------------
  // result side: the receiver never stalls, so every strobe is a transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    pending_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: line_width %0d pixel_value %0d overflow %0d",
                   line_width, pixel_value, overflow);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.res.ovf) n_ovf_results++;
        if (line_width !== want.res.width || pixel_value !== want.res.pix ||
            overflow !== want.res.ovf) begin
          errors++;
          if (errors <= 10)
            $display("mismatch on %s: line_width %0d/%0d pixel_value %0d/%0d overflow %0d/%0d",
                     want.op.name(), want.res.width, line_width, want.res.pix, pixel_value,
                     want.res.ovf, overflow);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one glyph by hand at the reset settings, then the obvious reads
  task automatic test_directed();
    int y, bits;
    gap_pct = 0;
    for (y = 0; y < MAX_HEIGHT; y++) begin
      case (y)
        0:       bits = 16'hFFFF;
        1:       bits = 16'h0000;
        2:       bits = 16'h8001;
        3:       bits = 16'hAAAA;
        4:       bits = 16'h5555;
        default: bits = $urandom;
      endcase
      // width walks up by row; the last load is over the maximum and saturates
      load_row(8'h41, y, bits, (y == MAX_HEIGHT - 1) ? 31 : y);
    end
    listed[8'h41] = 1'b1;
    font_codes.push_back(8'h41);
    n_glyphs++;
    start_line(8'hFF);
    append_char(8'h41);
    append_char(SPACE_CODE);
    read_pixel(0, 0);          // solid corner
    read_pixel(15, 2);         // last glyph column
    read_pixel(7, 1);          // blank row
    read_pixel(15, 8);         // row at the glyph height
    read_pixel(20, 0);         // at the pen
    read_pixel(17, 0);         // inside the space
  endtask

  // glyph definitions at the code extremes, random ones, and stray row loads
  task automatic test_font_loading();
    int i;
    gap_pct = 30;
    define_glyph(8'h00, 0);
    define_glyph(8'hFF, MAX_WIDTH);
    define_glyph(SPACE_CODE, MAX_WIDTH);   // space stays blank even when loaded
    define_glyph(8'h21, 1);
    define_glyph(8'h7E, MAX_WIDTH);
    for (i = 0; i < 9; i++) define_glyph($urandom_range(8'h21, 8'h7E), glyph_width_choice());
    for (i = 0; i < 20; i++)
      load_row($urandom_range(0, NUM_CODES - 1), $urandom_range(0, MAX_HEIGHT - 1),
               $urandom, $urandom_range(0, 31));
  endtask

  // strings under a series of register settings and sender idling levels
  task automatic test_line_rendering();
    int ph, first;
    font_cmd_t c;
    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_font_regs(256, 8, 8, 4);
        1: set_font_regs(0, 16, 16, 16);       // every code outside the font
        2: set_font_regs(256, 1, 1, 0);        // thinnest settings
        3: set_font_regs(33, 16, 16, 16);      // space is the last code inside
        4: set_font_regs(32, 4, 16, 0);        // space falls outside the font
        5: set_font_regs(100, 0, 5, 3);        // zero height blanks every read
        6: set_font_regs(200, 31, 16, 1);      // height above the maximum clamps
        default: set_font_regs($urandom_range(0, 256), $urandom_range(1, 16),
                               $urandom_range(1, 16), $urandom_range(0, 16));
      endcase
      gap_pct = (ph < 3) ? 30 : (ph < 6) ? 46 : 0;
      first = n_sent;
      while (n_sent - first < 50) begin
        case ($urandom_range(0, 9))
          0: define_glyph($urandom_range(0, NUM_CODES - 1), glyph_width_choice());
          1: begin
            // a stray command of any kind
            c = random_cmd();
            if (c.op == OP_APPEND) c.code = CODE_W'(pick_char());
            send_item(c);
          end
          default: run_line($urandom_range(1, 10));
        endcase
      end
    end
  endtask

  // lines that fill the buffer exactly and lines that run past it
  task automatic test_line_overflow();
    int i, extra;
    gap_pct = 0;
    // blanks of the full width: 64 of them land exactly on the line end
    set_font_regs(0, 16, 16, 0);
    start_line(8'hA5);
    for (i = 0; i < LINE_PIXELS / MAX_WIDTH; i++) append_char(pick_char());
    read_pixel(LINE_PIXELS - 1, 0);
    append_char(pick_char());
    read_pixel(LINE_PIXELS - 1, 3);
    // mixed glyphs and blanks until well past the end
    set_font_regs(128, 16, 16, 16);
    start_line($urandom_range(1, 255));
    extra = 0;
    i = 0;
    while (extra < 6 && i < 400) begin
      append_char(pick_char());
      if ($urandom_range(0, 4) == 0) read_random();
      if (line_ovf) extra++;
      i++;
    end
    repeat (8) read_pixel($urandom_range(LINE_PIXELS - 24, LINE_PIXELS - 1),
                          $urandom_range(0, MAX_HEIGHT - 1));
    // a new string clears the flag
    run_line(3);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    operation  = '0;
    char_code  = '0;
    glyph_row  = '0;
    row_bits   = '0;
    char_width = '0;
    fg_color   = '0;
    pixel_x    = '0;
    pixel_y    = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    font_count  = 256;
    font_height = 8;
    font_maxw   = 8;
    font_spacew = 4;
    pen        = 0;
    line_color = '0;
    line_ovf   = 1'b0;
    foreach (row_seen[i]) row_seen[i] = '0;
    foreach (listed[i]) listed[i] = 1'b0;
    gap_pct = 0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_glyphs = 0;
    n_strings = 0;
    n_ovf_results = 0;
    n_solid_reads = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_font_loading();
    test_line_rendering();
    test_line_overflow();

    // let anything stray show up after the last expected result
    wait_results_drained();
    repeat (40) @(posedge clk);

    $display("run covered %0d transfers: %0d glyph definitions, %0d strings, %0d results checked",
             n_sent, n_glyphs, n_strings, n_checked);
    $display("%0d results carried line overflow, %0d reads hit a solid pixel, %0d errors",
             n_ovf_results, n_solid_reads, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
